@@ hw/rtl/ntf_pkg.sv @@
// Shared types and constants for the non-empty tile finder.
// Used by the position tracker and the top level; no dependencies.
package ntf_pkg;

  localparam int unsigned CFG_W   = 13;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned ALPHA_W = 8;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TILE_WIDTH   = 2'd2,
    REG_TILE_HEIGHT  = 2'd3
  } cfg_reg_t;

  // Per-pixel facts worked out by the position tracker for the flag update stage.
  typedef struct packed {
    logic               active;
    logic               last;
    logic               first_row;
    logic               opaque;
    logic [COORD_W-1:0] tile_left;
    logic [COORD_W-1:0] tile_top;
  } pix_t;

endpackage

@@ hw/rtl/ntf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written in the same cycle returns the old contents.
module ntf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/ntf_pos.sv @@
// Raster position tracker: pixel, in-tile and tile-origin counters.
// Depends on ntf_pkg; advances once for every accepted pixel word.
module ntf_pos #(
  parameter int unsigned MAX_IMAGE_WIDTH  = 4096,
  parameter int unsigned MAX_IMAGE_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  logic [ntf_pkg::ALPHA_W-1:0]         alpha,
  input  logic                                frame_start,
  input  logic [ntf_pkg::CFG_W-1:0]           image_width,
  input  logic [ntf_pkg::CFG_W-1:0]           image_height,
  input  logic [ntf_pkg::CFG_W-1:0]           tile_width,
  input  logic [ntf_pkg::CFG_W-1:0]           tile_height,
  output ntf_pkg::pix_t                       pix,
  output logic [$clog2(MAX_IMAGE_WIDTH)-1:0]  col
);
  import ntf_pkg::*;

  localparam int unsigned XW  = $clog2(MAX_IMAGE_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_IMAGE_HEIGHT);
  localparam int unsigned XSW = ((XW > CFG_W) ? XW : CFG_W) + 1;
  localparam int unsigned YSW = ((YW > CFG_W) ? YW : CFG_W) + 1;

  logic [XW-1:0] px_r, px_nxt, xwt_r, xwt_nxt, left_r, left_nxt, col_r, col_nxt;
  logic [YW-1:0] py_r, py_nxt, ywt_r, ywt_nxt, top_r, top_nxt;

  logic [XW-1:0] px_c, xwt_c, left_c, col_c;
  logic [YW-1:0] py_c, ywt_c, top_c;
  logic [XSW-1:0] w, tw;
  logic [YSW-1:0] h, th;
  logic enabled, x_adv, y_adv, row_end, frame_end;

  // A frame start returns the counters to the origin before the pixel is used.
  assign px_c   = frame_start ? '0 : px_r;
  assign py_c   = frame_start ? '0 : py_r;
  assign xwt_c  = frame_start ? '0 : xwt_r;
  assign ywt_c  = frame_start ? '0 : ywt_r;
  assign left_c = frame_start ? '0 : left_r;
  assign top_c  = frame_start ? '0 : top_r;
  assign col_c  = frame_start ? '0 : col_r;

  assign w  = (XSW'(image_width) > XSW'(MAX_IMAGE_WIDTH)) ? XSW'(MAX_IMAGE_WIDTH)
                                                           : XSW'(image_width);
  assign h  = (YSW'(image_height) > YSW'(MAX_IMAGE_HEIGHT)) ? YSW'(MAX_IMAGE_HEIGHT)
                                                             : YSW'(image_height);
  assign tw = XSW'(tile_width);
  assign th = YSW'(tile_height);

  assign enabled = (tw != '0) && (th != '0) && (tw <= w) && (th <= h);

  always_comb begin
    pix.active    = enabled
                    && (XSW'(left_c) + tw <= w)
                    && (YSW'(top_c) + th <= h)
                    && (XSW'(col_c) < XSW'(MAX_IMAGE_WIDTH));
    pix.last      = (XSW'(xwt_c) + XSW'(1) == tw) && (YSW'(ywt_c) + YSW'(1) == th);
    pix.first_row = (ywt_c == '0);
    pix.opaque    = (alpha != '0);
    pix.tile_left = COORD_W'(left_c);
    pix.tile_top  = COORD_W'(top_c);
  end

  assign col = col_c;

  assign x_adv     = (XSW'(xwt_c) + XSW'(1) >= tw);
  assign y_adv     = (YSW'(ywt_c) + YSW'(1) >= th);
  assign row_end   = (XSW'(px_c) + XSW'(1) >= w);
  assign frame_end = (YSW'(py_c) + YSW'(1) >= h);

  always_comb begin
    px_nxt   = px_c + XW'(1);
    py_nxt   = py_c;
    ywt_nxt  = ywt_c;
    top_nxt  = top_c;
    if (x_adv) begin
      xwt_nxt  = '0;
      col_nxt  = col_c + XW'(1);
      left_nxt = left_c + XW'(tw);
    end else begin
      xwt_nxt  = xwt_c + XW'(1);
      col_nxt  = col_c;
      left_nxt = left_c;
    end
    if (row_end) begin
      px_nxt   = '0;
      xwt_nxt  = '0;
      col_nxt  = '0;
      left_nxt = '0;
      if (frame_end) begin
        py_nxt  = '0;
        ywt_nxt = '0;
        top_nxt = '0;
      end else begin
        py_nxt = py_c + YW'(1);
        if (y_adv) begin
          ywt_nxt = '0;
          top_nxt = top_c + YW'(th);
        end else begin
          ywt_nxt = ywt_c + YW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r   <= '0;
      py_r   <= '0;
      xwt_r  <= '0;
      ywt_r  <= '0;
      left_r <= '0;
      top_r  <= '0;
      col_r  <= '0;
    end else if (advance) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      xwt_r  <= xwt_nxt;
      ywt_r  <= ywt_nxt;
      left_r <= left_nxt;
      top_r  <= top_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

@@ hw/rtl/nonempty_tile_finder_core.sv @@
// Top level of the non-empty tile finder: configuration, flag memory and result register.
// Depends on ntf_pkg, ntf_pos and ntf_ram.
//
// The block takes one pixel alpha word per clock and reports the top-left corner of every
// whole tile that holds a nonzero alpha, in tile rows from left to right. Each pixel's
// tile-column flag is read from a one-bit-wide memory of MAX_IMAGE_WIDTH entries on
// acceptance, and updated and written back in the update stage, which loads the result
// register, with the flag forwarded when consecutive pixels share a tile column. Input is
// held off only while a result waits for out_tready and a word sits in the update stage.
// The flag memory needs no clearing, as the first pixel row of each tile overwrites its
// entry. The user must write configuration only while idle; the block does not enforce it.
module nonempty_tile_finder_core #(
  parameter int unsigned MAX_IMAGE_WIDTH  = 4096,
  parameter int unsigned MAX_IMAGE_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Pixel stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] alpha
  input  logic [0:0]                       in_tuser,   // [0] frame_start
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // [11:0] tile_left, [23:12] tile_top
  // Configuration writes.
  input  logic                             cfg_wr_en,
  input  logic [1:0]                       cfg_addr,
  input  logic [ntf_pkg::CFG_W-1:0]        cfg_wdata
);
  import ntf_pkg::*;

  localparam int unsigned XW = $clog2(MAX_IMAGE_WIDTH);

  logic [CFG_W-1:0] img_w_r, img_h_r, tile_w_r, tile_h_r;

  pix_t          pix, p1_info_r;
  logic [XW-1:0] col, p1_col_r;
  logic          p1_valid_r, p1_fwd_r, p1_fwd_val_r;
  logic          accept, s1_go, flag_old, seen, emit, wr_en, rd_flag;
  logic          out_tvalid_r;
  logic [23:0]   out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= CFG_W'(1);
      img_h_r  <= CFG_W'(1);
      tile_w_r <= '0;
      tile_h_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_IMAGE_WIDTH:  img_w_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: img_h_r  <= cfg_wdata;
        REG_TILE_WIDTH:   tile_w_r <= cfg_wdata;
        REG_TILE_HEIGHT:  tile_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The update stage moves on whenever the result register has room.
  assign s1_go     = p1_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready = !p1_valid_r || s1_go;
  assign accept    = in_tvalid && in_tready;

  ntf_pos #(
    .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (accept),
    .alpha        (in_tdata),
    .frame_start  (in_tuser[0]),
    .image_width  (img_w_r),
    .image_height (img_h_r),
    .tile_width   (tile_w_r),
    .tile_height  (tile_h_r),
    .pix          (pix),
    .col          (col)
  );

  ntf_ram #(
    .WIDTH (1),
    .DEPTH (MAX_IMAGE_WIDTH)
  ) u_flags (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (p1_col_r),
    .wr_data (seen),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_flag)
  );

  // The memory returns the old flag when the word ahead writes the same column in the
  // cycle of the read, so that value is caught here instead.
  assign flag_old = p1_fwd_r ? p1_fwd_val_r : rd_flag;
  assign seen     = (!p1_info_r.first_row && flag_old) || p1_info_r.opaque;
  assign wr_en    = s1_go && p1_info_r.active;
  assign emit     = p1_info_r.active && p1_info_r.last && seen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (accept) begin
      p1_valid_r <= 1'b1;
    end else if (s1_go) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_info_r    <= pix;
      p1_col_r     <= col;
      p1_fwd_r     <= wr_en && (p1_col_r == col);
      p1_fwd_val_r <= seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_tdata_r <= {p1_info_r.tile_top, p1_info_r.tile_left};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_fwd_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && wr_en && (p1_col_r == col)) |=> p1_fwd_r)
    else $error("same-column flag not forwarded");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_valid_r && !s1_go) |=> (p1_valid_r && $stable(p1_col_r)))
    else $error("update stage lost a stalled word");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(p1_valid_r && p1_info_r.active && p1_info_r.last))
    else $error("result raised without a finished tile");

  a_no_read_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_valid_r && !s1_go) |-> !accept)
    else $error("pixel accepted while the update stage is stalled");
`endif

endmodule
